// File: rtl/core/ldsh_pkg.sv
package ldsh_pkg;

    // three signed Q3.12 (or Q1.14) lanes, x lowest
    typedef logic [2:0][15:0] t_vec;

    // configuration register indexes
    localparam logic [2:0] REG_LIGHT_DIR = 3'd0;
    localparam logic [2:0] REG_AMB_LIGHT = 3'd1;
    localparam logic [2:0] REG_AMB_MAT   = 3'd2;
    localparam logic [2:0] REG_DIF_LIGHT = 3'd3;
    localparam logic [2:0] REG_DIF_MAT   = 3'd4;

    localparam int          CFG_IDX_W   = 3;
    localparam int          CFG_DATA_W  = 64;
    localparam logic [15:0] ALPHA_CONST = 16'd9830;
    localparam logic [14:0] NDL_ONE     = 15'd16384;
    // ceil(2^26 / 5): exact floor(w / 5) for w below 2^23
    localparam logic [23:0] RECIP_FIVE  = 24'd13421773;
    localparam int          RECIP_SHIFT = 26;

endpackage

// File: rtl/core/ldsh_unit.sv
module ldsh_unit
    import ldsh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_vec i_vec,
    output logic o_valid,
    output logic o_zero,
    output t_vec o_unit
);

    localparam int NSQ  = 16;
    localparam int NDIV = 8;
    localparam int NST  = 2 + NSQ + NDIV;

    typedef struct packed {
        logic             zero;
        logic [2:0]       neg;
        logic [2:0][15:0] mag;
        logic [2:0][31:0] sqr;
        logic [63:0]      rem;
        logic [63:0]      root;
        logic [2:0][46:0] drem;
        logic [2:0][14:0] quo;
    } t_ust;

    t_ust           r_st [NST];
    t_ust           n_st [NST];
    logic [NST-1:0] r_vld;

    for (genvar k = 0; k < NST; k++) begin : g_stage
        if (k == 0) begin : g_sq
            always_comb begin
                n_st[k] = '0;
                for (int i = 0; i < 3; i++) begin
                    n_st[k].neg[i] = i_vec[i][15];
                    n_st[k].mag[i] = i_vec[i][15] ? 16'(-i_vec[i]) : i_vec[i];
                    n_st[k].sqr[i] = 32'(n_st[k].mag[i]) * 32'(n_st[k].mag[i]);
                end
            end
        end else if (k == 1) begin : g_sum
            always_comb begin
                logic [31:0] sum;
                sum = r_st[k-1].sqr[0] + r_st[k-1].sqr[1] + r_st[k-1].sqr[2];
                n_st[k]      = r_st[k-1];
                n_st[k].zero = (sum == 32'd0);
                n_st[k].rem  = {2'b00, sum, 30'd0};
                n_st[k].root = '0;
            end
        end else if (k < 2 + NSQ) begin : g_sqrt
            // two root bits per stage
            always_comb begin
                logic [63:0] bitv;
                logic [63:0] trial;
                n_st[k] = r_st[k-1];
                for (int t = 0; t < 2; t++) begin
                    bitv  = 64'd1 << (62 - 2 * (2 * (k - 2) + t));
                    trial = n_st[k].root + bitv;
                    if (n_st[k].rem >= trial) begin
                        n_st[k].rem  = n_st[k].rem - trial;
                        n_st[k].root = (n_st[k].root >> 1) + bitv;
                    end else begin
                        n_st[k].root = n_st[k].root >> 1;
                    end
                end
            end
        end else begin : g_div
            // two quotient bits per stage (one in the last), all three lanes side by side
            always_comb begin
                logic [46:0] dvs;
                n_st[k] = r_st[k-1];
                if (k == 2 + NSQ) begin
                    for (int i = 0; i < 3; i++) begin
                        n_st[k].drem[i] = {2'b00, n_st[k].mag[i], 29'd0};
                        n_st[k].quo[i]  = '0;
                    end
                end
                for (int t = 0; t < 2; t++) begin
                    if (14 - 2 * (k - 2 - NSQ) - t >= 0) begin
                        for (int i = 0; i < 3; i++) begin
                            dvs = {15'd0, n_st[k].root[31:0]}
                                  << (14 - 2 * (k - 2 - NSQ) - t);
                            if (n_st[k].drem[i] >= dvs) begin
                                n_st[k].drem[i] = n_st[k].drem[i] - dvs;
                                n_st[k].quo[i][14 - 2 * (k - 2 - NSQ) - t] = 1'b1;
                            end
                        end
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_zero  = r_st[NST-1].zero;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_unit[i] = r_st[NST-1].neg[i] ? 16'(-{1'b0, r_st[NST-1].quo[i]})
                                           : {1'b0, r_st[NST-1].quo[i]};
        end
    end

endmodule

// File: rtl/core/ldsh_color.sv
module ldsh_color
    import ldsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_vec        i_un,
    input  t_vec        i_ul,
    input  logic        i_zero_n,
    input  logic        i_zero_l,
    input  logic [63:0] i_al,
    input  logic [63:0] i_am,
    input  logic [63:0] i_dl,
    input  logic [63:0] i_dm,
    output logic        o_valid,
    output logic [15:0] o_color_r,
    output logic [15:0] o_color_g
);

    logic [5:0]              r_vld;
    logic signed [2:0][31:0] r1_p;
    logic [1:0][31:0]        r1_amb, r1_dif, r2_amb, r2_dif;
    logic                    r1_z;
    logic [14:0]             r2_ndl;
    logic [1:0][47:0]        r3_sum;
    logic [1:0][22:0]        r4_w;
    logic [1:0][20:0]        r5_q;
    logic [1:0][15:0]        r6_c;

    logic signed [33:0] n_dot;
    logic [14:0]        n_ndl;

    always_comb begin
        n_dot = 34'($signed(r1_p[0])) + 34'($signed(r1_p[1])) + 34'($signed(r1_p[2]));
        if (r1_z || n_dot <= 0) begin
            n_ndl = '0;
        end else if (n_dot[33:14] > 20'(NDL_ONE)) begin
            n_ndl = NDL_ONE;
        end else begin
            n_ndl = n_dot[28:14];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_p[i] <= $signed(i_un[i]) * $signed(i_ul[i]);
            end
            r1_z   <= i_zero_n | i_zero_l;
            r2_ndl <= n_ndl;
            for (int c = 0; c < 2; c++) begin
                r1_amb[c] <= i_al[16*c +: 16] * i_am[16*c +: 16];
                r1_dif[c] <= i_dl[16*c +: 16] * i_dm[16*c +: 16];
                r2_amb[c] <= r1_amb[c];
                r2_dif[c] <= r1_dif[c];
                r3_sum[c] <= {2'b00, r2_amb[c], 14'd0} + 48'(r2_dif[c]) * 48'(r2_ndl);
                r4_w[c]   <= 23'((({3'b000, r3_sum[c]} << 2)
                                  + ({3'b000, r3_sum[c]} << 1)) >> 28);
                r5_q[c]   <= 21'(({24'd0, r4_w[c]} * RECIP_FIVE) >> RECIP_SHIFT);
                r6_c[c]   <= (r5_q[c] > 21'd65535) ? 16'hFFFF : r5_q[c][15:0];
            end
        end
    end

    assign o_valid   = r_vld[5];
    assign o_color_r = r6_c[0];
    assign o_color_g = r6_c[1];

endmodule

// File: rtl/core/lambert_diffuse_shade.sv
// Channel  Direction  Handshake                   Word
// input    in         i_in_valid / o_in_ready     i_normal_x, i_normal_y, i_normal_z
// output   out        o_out_valid / i_out_ready   o_color_r, o_color_g, o_color_b, o_color_a
// config   in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One word enters per cycle while the output is not stalled. Stages: 26 normalize (square,
// sum, 16 two-bit square-root stages, 8 divide stages of up to two bits), then 6 color.
// The light vector runs through its own copy of the normalize pipeline beside the normal.
// Synchronous active-low reset clears all valid bits and the configuration registers.
// A stalled output word freezes the whole pipeline; nothing is dropped or repeated.
module lambert_diffuse_shade
    import ldsh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [15:0]    i_normal_x,
    input  logic signed [15:0]    i_normal_y,
    input  logic signed [15:0]    i_normal_z,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [15:0]           o_color_r,
    output logic [15:0]           o_color_g,
    output logic [15:0]           o_color_b,
    output logic [15:0]           o_color_a,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [47:0] r_light;
    logic [63:0] r_amb_light, r_amb_mat, r_dif_light, r_dif_mat;

    logic en;
    logic n_valid, n_zero, l_zero;
    t_vec n_unit, l_unit;

    // advance whenever the output register is empty or being drained
    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light     <= '0;
            r_amb_light <= '0;
            r_amb_mat   <= '0;
            r_dif_light <= '0;
            r_dif_mat   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LIGHT_DIR: r_light     <= i_cfg_data[47:0];
                REG_AMB_LIGHT: r_amb_light <= i_cfg_data;
                REG_AMB_MAT:   r_amb_mat   <= i_cfg_data;
                REG_DIF_LIGHT: r_dif_light <= i_cfg_data;
                REG_DIF_MAT:   r_dif_mat   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // normal lane: valid travels here
    ldsh_unit u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_vec   ({i_normal_z, i_normal_y, i_normal_x}),
        .o_valid (n_valid),
        .o_zero  (n_zero),
        .o_unit  (n_unit)
    );

    // light lane: fed from the register every cycle the pipeline advances, stays aligned with the normal
    ldsh_unit u_light (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (1'b1),
        .i_vec   (r_light),
        .o_valid (),
        .o_zero  (l_zero),
        .o_unit  (l_unit)
    );

    ldsh_color u_color (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (n_valid),
        .i_un      (n_unit),
        .i_ul      (l_unit),
        .i_zero_n  (n_zero),
        .i_zero_l  (l_zero),
        .i_al      (r_amb_light),
        .i_am      (r_amb_mat),
        .i_dl      (r_dif_light),
        .i_dm      (r_dif_mat),
        .o_valid   (o_out_valid),
        .o_color_r (o_color_r),
        .o_color_g (o_color_g)
    );

    // blue is scaled by zero; alpha is the fixed 0.6 offset
    assign o_color_b = '0;
    assign o_color_a = ALPHA_CONST;

endmodule

// File: rtl/core/ldsh_checker.sv
module ldsh_checker
    import ldsh_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_color_r,
    input logic [15:0] o_color_b,
    input logic [15:0] o_color_a
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_color_r))
        else $error("stalled output word changed");

    a_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_color_b == 16'd0 && o_color_a == ALPHA_CONST)
        else $error("blue or alpha wrong");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while pipeline frozen");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind lambert_diffuse_shade ldsh_checker u_ldsh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_color_r   (o_color_r),
    .o_color_b   (o_color_b),
    .o_color_a   (o_color_a)
);
